[rtl/mlr_pkg.sv]
// mlr_pkg: shared types and constants of the matrix line rotator
// command codes, channel payloads, divider handshake structs and fsm states
// no dependencies
package mlr_pkg;

    localparam int MLR_MAX_DIM = 32;
    localparam int CNT_W       = 6;
    localparam int IDX_W       = 6;
    localparam int AMT_W       = 16;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

    typedef enum logic [2:0] {
        CMD_WRITE    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_ROW_RIGHT = 3'd2,
        CMD_ROW_LEFT = 3'd3,
        CMD_COL_UP   = 3'd4,
        CMD_COL_DOWN = 3'd5
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_COL_COUNT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0]              command;
        logic [IDX_W-1:0]        line_index;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
        logic [AMT_W-1:0]        amount;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     status;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CNT_W-1:0]     data;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [AMT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_mod_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_MOD,
        ST_LOAD,
        ST_STORE,
        ST_FINISH
    } t_state;

endpackage

[rtl/mlr_if.sv]
// mlr_if: valid/ready channels for commands, results and configuration writes
// depends on mlr_pkg for the payload types
interface mlr_cmd_if;
    import mlr_pkg::*;
    logic valid;
    logic ready;
    t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mlr_res_if;
    import mlr_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mlr_cfg_if;
    import mlr_pkg::*;
    logic valid;
    logic ready;
    t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/mlr_ram.sv]
// mlr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/mlr_mod.sv]
// mlr_mod: bit-serial restoring remainder of the rotate amount by the line length
// depends on mlr_pkg; one quotient bit per cycle
module mlr_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlr_pkg::t_mod_req i_req,
    output mlr_pkg::t_mod_rsp o_rsp
);
    import mlr_pkg::*;

    localparam int STEP_W = $clog2(AMT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [AMT_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_q[AMT_W-1]};
        n_rem = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem[CNT_W-1:0];
            r_q   <= {r_q[AMT_W-2:0], 1'b0};
            r_cnt <= r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(AMT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
endmodule

[rtl/matrix_line_rotator_core.sv]
// matrix_line_rotator_core: matrix of signed words with element access and line rotation
// a write goes straight to the finish state, a read passes through a wait state for the registered ram read,
// and a rotation runs the 16-step remainder unit and then copies the line out to and back from a buffer ram
// one command in flight at a time; a finished result waits in the output register
// reset clears control state and sets both counts to 32; matrix contents are not cleared
module matrix_line_rotator_core #(
    parameter int MAX_DIM = mlr_pkg::MLR_MAX_DIM
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mlr_cmd_if.sink   i_cmd,
    mlr_res_if.source o_res,
    mlr_cfg_if.sink   i_cfg
);
    import mlr_pkg::*;

    localparam int AW        = $clog2(MAX_DIM);
    localparam int KW        = $clog2(MAX_DIM + 1);
    localparam int MAT_DEPTH = 2 ** (2 * AW);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_row_count, r_col_count;
    logic [CNT_W-1:0] nr, nc;

    logic             r_is_row;
    logic             r_left;
    logic [AW-1:0]    r_line;
    logic [CNT_W-1:0] r_n;
    logic             r_status;
    logic [DATA_W-1:0] r_rd;
    logic [KW-1:0]    r_k;
    logic [AW-1:0]    r_prev;
    logic [AW-1:0]    r_dst;
    logic             r_out_valid;
    t_res             r_out;

    t_cmd        cmd;
    logic        accept;
    logic        elem_ok, row_ok, col_ok;
    logic [2*AW-1:0] elem_addr;
    logic        k_end;
    logic [CNT_W-1:0] shift;

    logic              mat_we;
    logic [2*AW-1:0]   mat_waddr, mat_raddr;
    logic [DATA_W-1:0] mat_wdata, mat_rdata;
    logic              buf_we;
    logic [DATA_W-1:0] buf_rdata;

    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    // counts in use saturate at the array size
    assign nr = (32'(r_row_count) > MAX_DIM) ? CNT_W'(MAX_DIM) : r_row_count;
    assign nc = (32'(r_col_count) > MAX_DIM) ? CNT_W'(MAX_DIM) : r_col_count;

    assign cmd     = i_cmd.payload;
    assign accept  = i_cmd.valid && (r_state == ST_IDLE);
    assign elem_ok = (cmd.row != '0) && (cmd.row <= nr) && (cmd.col != '0) && (cmd.col <= nc);
    assign row_ok  = (cmd.line_index != '0) && (cmd.line_index <= nr) && (nc != '0);
    assign col_ok  = (cmd.line_index != '0) && (cmd.line_index <= nc) && (nr != '0);
    assign elem_addr = {AW'(cmd.row - 6'd1), AW'(cmd.col - 6'd1)};
    assign k_end   = (r_k == KW'(r_n));

    // left and up turn into the complementary right or down shift
    assign shift = (r_left && (mod_rsp.rem != '0)) ? r_n - mod_rsp.rem : mod_rsp.rem;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd.command)
                        CMD_READ:      n_state = elem_ok ? ST_RDWAIT : ST_FINISH;
                        CMD_ROW_RIGHT,
                        CMD_ROW_LEFT:  n_state = row_ok ? ST_MOD : ST_FINISH;
                        CMD_COL_UP,
                        CMD_COL_DOWN:  n_state = col_ok ? ST_MOD : ST_FINISH;
                        default:       n_state = ST_FINISH;
                    endcase
                end
            end
            ST_RDWAIT: n_state = ST_FINISH;
            ST_MOD: begin
                if (mod_rsp.done) begin
                    n_state = (shift == '0) ? ST_FINISH : ST_LOAD;
                end
            end
            ST_LOAD:   if (k_end) n_state = ST_STORE;
            ST_STORE:  if (k_end) n_state = ST_FINISH;
            ST_FINISH: if (!r_out_valid || o_res.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // memory, divider and handshake controls
    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = elem_addr;
        mat_wdata = cmd.value;
        mat_raddr = elem_addr;
        buf_we    = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = cmd.amount;
        mod_req.divisor  = row_ok ? nc : nr;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd.command)
                        CMD_WRITE: mat_we = elem_ok;
                        CMD_ROW_RIGHT,
                        CMD_ROW_LEFT: begin
                            mod_req.start   = row_ok;
                            mod_req.divisor = nc;
                        end
                        CMD_COL_UP,
                        CMD_COL_DOWN: begin
                            mod_req.start   = col_ok;
                            mod_req.divisor = nr;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                mat_raddr = r_is_row ? {r_line, r_k[AW-1:0]} : {r_k[AW-1:0], r_line};
                buf_we    = (r_k != '0);
            end
            ST_STORE: begin
                mat_we    = (r_k != '0);
                mat_waddr = r_is_row ? {r_line, r_prev} : {r_prev, r_line};
                mat_wdata = buf_rdata;
            end
            default: ;
        endcase
    end

    assign i_cmd.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_row_count <= CNT_RESET;
            r_col_count <= CNT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.payload.index)
                    CFG_ROW_COUNT: r_row_count <= i_cfg.payload.data;
                    CFG_COL_COUNT: r_col_count <= i_cfg.payload.data;
                    default: ;
                endcase
            end
            if (r_state == ST_FINISH && n_state == ST_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_is_row <= (cmd.command == CMD_ROW_RIGHT) || (cmd.command == CMD_ROW_LEFT);
                    r_left   <= (cmd.command == CMD_ROW_LEFT) || (cmd.command == CMD_COL_UP);
                    r_line   <= AW'(cmd.line_index - 6'd1);
                    r_n      <= ((cmd.command == CMD_ROW_RIGHT) || (cmd.command == CMD_ROW_LEFT))
                                ? nc : nr;
                    r_rd     <= '0;
                    r_k      <= '0;
                    case (cmd.command)
                        CMD_WRITE,
                        CMD_READ:      r_status <= !elem_ok;
                        CMD_ROW_RIGHT,
                        CMD_ROW_LEFT:  r_status <= !row_ok;
                        CMD_COL_UP,
                        CMD_COL_DOWN:  r_status <= !col_ok;
                        default:       r_status <= 1'b1;
                    endcase
                end
            end
            ST_RDWAIT: r_rd <= mat_rdata;
            ST_MOD: begin
                r_dst <= AW'(shift);
                r_k   <= '0;
            end
            ST_LOAD: begin
                r_k    <= k_end ? '0 : r_k + KW'(1);
                r_prev <= r_k[AW-1:0];
                if (r_k != '0) begin
                    r_dst <= (r_dst == AW'(r_n - 6'd1)) ? '0 : r_dst + AW'(1);
                end
            end
            ST_STORE: begin
                r_k    <= r_k + KW'(1);
                r_prev <= r_k[AW-1:0];
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    r_out.read_value <= r_rd;
                    r_out.status     <= r_status;
                end
            end
            default: ;
        endcase
    end

    mlr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (mat_wdata),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    // line buffer: element k of the line lands at (k + shift) mod n
    mlr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DIM)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_dst),
        .i_wdata (mat_rdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (buf_rdata)
    );

    mlr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );
endmodule

[rtl/mlr_checker.sv]
// mlr_checker: port-level assertions for matrix_line_rotator_core
// bound to the top level; depends only on its port signals
module mlr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_res_read_value,
    input logic        i_res_status
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_read_value) && $stable(i_res_status))
        else $error("result changed while stalled");

    // an ignored command never returns data
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status |-> i_res_read_value == 32'd0)
        else $error("nonzero read value with range status");

    // one command at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while busy");

    // a new result only comes out of a busy cycle
    a_res_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_cmd_ready))
        else $error("result without a command in flight");
endmodule

bind matrix_line_rotator_core mlr_checker u_mlr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_read_value (o_res.payload.read_value),
    .i_res_status     (o_res.payload.status)
);
